### hw/rtl/lxdln_pkg.sv
// ----------------------------------------------------------------------------
// lxdln_pkg
// Shared constants, codes and types of the descrambler and line normalizer.
// ----------------------------------------------------------------------------
package lxdln_pkg;

   localparam int GEN_W  = 24;
   localparam int SKIP_W = 6;
   localparam int BYTE_W = 8;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 2;
   localparam int IDX_W  = 2;

   // low 24 bits of the multiplier; the state wraps at 2^24
   localparam logic [GEN_W-1:0]  GEN_MUL    = 24'hfd43fd;
   localparam logic [GEN_W-1:0]  GEN_ADD    = 24'hc39ec3;
   localparam logic [GEN_W-1:0]  SEED_RESET = 24'ha09e86;
   localparam logic [SKIP_W-1:0] SKIP_RESET = 6'd14;

   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

   localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
   localparam logic [OP_W-1:0] OP_END     = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   localparam logic [STAT_W-1:0] ST_NONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_CRLF  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNTERM = 2'd2;

   localparam logic [IDX_W-1:0] REG_SEED   = 2'd0;
   localparam logic [IDX_W-1:0] REG_SKIP   = 2'd1;
   localparam logic [IDX_W-1:0] REG_ENABLE = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic [STAT_W-1:0] end_status;
      logic              last;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      result_type       r0;
      result_type       r1;
   } result_pair_type;

   typedef struct packed {
      logic step;
      logic restart;
   } gen_ctl_type;

   typedef struct packed {
      logic [BYTE_W-1:0] key;
      logic              skip;
   } key_type;

endpackage

### hw/rtl/lxdln_keygen.sv
// ----------------------------------------------------------------------------
// lxdln_keygen
// 24-bit congruential generator with header skip counter.
// ----------------------------------------------------------------------------
module lxdln_keygen
   import lxdln_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  gen_ctl_type       ctl,
   input  logic [GEN_W-1:0]  seed,
   input  logic [SKIP_W-1:0] header_skip,
   output key_type           key_out
);

   logic [GEN_W-1:0]  gen_state_ff;
   logic [GEN_W-1:0]  gen_state_in;
   logic [SKIP_W-1:0] header_left_ff;
   logic [SKIP_W-1:0] header_left_in;
   logic [GEN_W-1:0]  gen_next;
   logic [31:0]       key_scaled;

   assign gen_next   = gen_state_ff * GEN_MUL + GEN_ADD;
   assign key_scaled = {gen_next, 8'h00} - {8'h00, gen_next};

   assign key_out.key  = key_scaled[31:24];
   assign key_out.skip = (header_left_ff != '0);

   always_comb begin
      gen_state_in   = gen_state_ff;
      header_left_in = header_left_ff;
      if (ctl.restart) begin
         gen_state_in   = seed;
         header_left_in = header_skip;
      end else if (ctl.step) begin
         gen_state_in = gen_next;
         if (header_left_ff != '0) begin
            header_left_in = header_left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff   <= SEED_RESET;
         header_left_ff <= SKIP_RESET;
      end else begin
         gen_state_ff   <= gen_state_in;
         header_left_ff <= header_left_in;
      end
   end

endmodule

### hw/rtl/lxdln_norm.sv
// ----------------------------------------------------------------------------
// lxdln_norm
// Key XOR and line normalization; holds CR and the end-of-data status.
// ----------------------------------------------------------------------------
module lxdln_norm
   import lxdln_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [OP_W-1:0]   operation,
   input  logic [BYTE_W-1:0] data_byte,
   input  key_type           key_in,
   input  logic              descramble_enable,
   output result_pair_type   results
);

   logic              held_cr_ff;
   logic              held_cr_in;
   logic              ended_crlf_ff;
   logic              ended_crlf_in;
   logic [BYTE_W-1:0] dec_byte;
   logic [BYTE_W-1:0] plain_byte;
   result_type        data_res;
   result_type        lf_res;
   result_type        nul_res;
   result_type        stat_res;

   assign dec_byte   = descramble_enable ? (data_byte ^ key_in.key) : data_byte;
   assign plain_byte = (dec_byte == CH_NUL) ? CH_LF : dec_byte;

   always_comb begin
      data_res = '{out_byte: plain_byte, byte_valid: 1'b1, end_status: ST_NONE, last: 1'b1};
      lf_res   = '{out_byte: CH_LF, byte_valid: 1'b1, end_status: ST_NONE, last: 1'b0};
      nul_res  = '{out_byte: CH_NUL, byte_valid: 1'b1, end_status: ST_NONE, last: 1'b0};
      stat_res = '{out_byte: CH_NUL, byte_valid: 1'b0,
                   end_status: ended_crlf_ff ? ST_CRLF : ST_UNTERM, last: 1'b1};

      results       = '0;
      held_cr_in    = held_cr_ff;
      ended_crlf_in = ended_crlf_ff;

      case (operation)
         OP_RESTART: begin
            held_cr_in    = 1'b0;
            ended_crlf_in = 1'b1;
         end
         OP_END: begin
            held_cr_in = 1'b0;
            if (held_cr_ff) begin
               results.count = 2'd2;
               results.r0    = lf_res;
               results.r1    = stat_res;
            end else begin
               results.count = 2'd1;
               results.r0    = stat_res;
            end
         end
         OP_DATA: begin
            if (!key_in.skip) begin
               if (held_cr_ff) begin
                  held_cr_in = 1'b0;
                  if (dec_byte == CH_LF) begin
                     results.count = 2'd2;
                     results.r0    = nul_res;
                     results.r1    = nul_res;
                     results.r1.last = 1'b1;
                     ended_crlf_in = 1'b1;
                  end else begin
                     ended_crlf_in = 1'b0;
                     results.r0    = lf_res;
                     if (dec_byte == CH_CR) begin
                        held_cr_in      = 1'b1;
                        results.count   = 2'd1;
                        results.r0.last = 1'b1;
                     end else begin
                        results.count = 2'd2;
                        results.r1    = data_res;
                     end
                  end
               end else begin
                  ended_crlf_in = 1'b0;
                  if (dec_byte == CH_CR) begin
                     held_cr_in = 1'b1;
                  end else begin
                     results.count = 2'd1;
                     results.r0    = data_res;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cr_ff    <= 1'b0;
         ended_crlf_ff <= 1'b1;
      end else if (fire) begin
         held_cr_ff    <= held_cr_in;
         ended_crlf_ff <= ended_crlf_in;
      end
   end

endmodule

### hw/rtl/lxdln_outbuf.sv
// ----------------------------------------------------------------------------
// lxdln_outbuf
// Two-slot result buffer; takes up to two results per item, sends one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module lxdln_outbuf
   import lxdln_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_pair_type results,
   output logic            space,
   output logic            out_valid,
   input  logic            out_ready,
   output result_type      out_res
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   result_type       slot0_ff;
   result_type       slot0_in;
   result_type       slot1_ff;
   result_type       slot1_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_res   = slot0_ff;
   assign pop       = out_valid && out_ready;
   assign space     = (count_ff == 2'd0) || ((count_ff == 2'd1) && out_ready);

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push) begin
         count_in = results.count;
         slot0_in = results.r0;
         slot1_in = results.r1;
      end else if (pop) begin
         count_in = count_ff - 1'b1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

### hw/rtl/lcg_xor_descrambler_line_normalizer.sv
// ----------------------------------------------------------------------------
// lcg_xor_descrambler_line_normalizer
// Keystream descrambler for file bytes with CR/LF line normalization.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata data_byte, tuser operation
//   rsp      out        rsp_tvalid/rsp_tready  tdata out_byte, tuser status, tlast
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item a cycle enters the input register; key, XOR and normalization run
// between it and a two-slot result buffer, so an item with one result sustains
// one item per cycle while rsp is ready. Two results make two rsp transfers.
// A stalled rsp holds the buffer; req stalls if the full input register cannot
// fire. Reset loads seed 0xa09e86, skip 14, descrambling on; no clearing pass.
// ----------------------------------------------------------------------------
module lcg_xor_descrambler_line_normalizer
   import lxdln_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic [OP_W-1:0]   req_tuser,   // [1:0] operation
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0]        rsp_tuser,   // [0] byte_valid, [2:1] end_status
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [GEN_W-1:0]  csr_data
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [OP_W-1:0]   in_op_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [GEN_W-1:0]  seed_ff;
   logic [SKIP_W-1:0] header_skip_ff;
   logic              enable_ff;
   logic              fire;
   logic              space;
   logic              req_take;
   gen_ctl_type       gen_ctl;
   key_type           key;
   result_pair_type   results;
   result_type        out_res;

   assign csr_ready  = 1'b1;
   assign fire       = in_valid_ff && space;
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   assign gen_ctl.step    = fire && (in_op_ff == OP_DATA);
   assign gen_ctl.restart = fire && (in_op_ff == OP_RESTART);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         seed_ff        <= SEED_RESET;
         header_skip_ff <= SKIP_RESET;
         enable_ff      <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SEED:   seed_ff        <= csr_data;
               REG_SKIP:   header_skip_ff <= csr_data[SKIP_W-1:0];
               REG_ENABLE: enable_ff      <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   lxdln_keygen u_keygen (
      .clock       (clock),
      .reset       (reset),
      .ctl         (gen_ctl),
      .seed        (seed_ff),
      .header_skip (header_skip_ff),
      .key_out     (key)
   );

   lxdln_norm u_norm (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .operation         (in_op_ff),
      .data_byte         (in_byte_ff),
      .key_in            (key),
      .descramble_enable (enable_ff),
      .results           (results)
   );

   lxdln_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .results   (results),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = out_res.out_byte;
   assign rsp_tuser = {out_res.end_status, out_res.byte_valid};
   assign rsp_tlast = out_res.last;

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_op_ff == OP_END)) |=> rsp_tvalid)
      else $error("end item produced no result");

   a_fire_has_room: assert property (@(posedge clock) disable iff (reset)
      fire |-> (!rsp_tvalid || rsp_tready))
      else $error("item processed while result buffer busy");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tlast && (rsp_tdata == CH_NUL)))
      else $error("status result not last or carries data");

   a_status_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[2:1] == ST_NONE)))
      else $error("end status inconsistent with byte_valid");

endmodule
